/* sv/psrq_pkg.sv */
// psrq_pkg: types and constants shared by the sorted ready queue scheduler
// used by psrq_ring and preemptive_sorted_ready_queue_core; no dependencies
package psrq_pkg;

  localparam int DefQueueDepth = 16;
  localparam int IdW           = 8;
  localparam int PrioW         = 8;
  localparam int TimeW         = 16;
  localparam int QCountW       = 5;

  localparam logic KindArrival  = 1'b0;
  localparam logic KindTickOnly = 1'b1;

  localparam logic ModeRemaining = 1'b0;
  localparam logic ModePriority  = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [IdW-1:0]   process_id;
    logic [PrioW-1:0] priority_req;
    logic [TimeW-1:0] burst_time;
  } sched_in_t;

  typedef struct packed {
    logic               running_valid;
    logic [IdW-1:0]     running_id;
    logic               finished_valid;
    logic [IdW-1:0]     finished_id;
    logic               preempted;
    logic               dropped;
    logic [QCountW-1:0] queue_count;
  } sched_out_t;

  // one queue entry as held in the ring memory
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
    logic [TimeW-1:0] remaining;
  } slot_t;

  // ring control from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic pop;
  } ring_ctl_t;

  // sort key of an entry under the given mode
  function automatic logic [TimeW-1:0] key_of(input logic mode, input slot_t s);
    logic [TimeW-1:0] k;
    k = (mode == ModePriority) ? TimeW'(s.prio) : s.remaining;
    return k;
  endfunction

endpackage

/* sv/psrq_ring.sv */
// psrq_ring: circular entry store for the ready queue, addressed by position
// from the head; one write and one registered read a cycle; uses psrq_pkg
module psrq_ring import psrq_pkg::*; #(
  parameter int QUEUE_DEPTH = DefQueueDepth,
  parameter int AW          = $clog2(QUEUE_DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ring_ctl_t     ctl_i,
  input  logic [AW-1:0] rd_idx_i,
  input  logic [AW-1:0] wr_idx_i,
  input  slot_t         wr_data_i,
  output slot_t         rd_data_o
);

  slot_t         mem [QUEUE_DEPTH];
  slot_t         rd_data_q;
  logic [AW-1:0] base_q, base_d;
  logic [AW-1:0] rd_addr, wr_addr;

  // head position plus offset, wrapped at the depth
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(QUEUE_DEPTH)) begin
      s = s - (AW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign rd_addr = wrap_add(base_q, rd_idx_i);
  assign wr_addr = wrap_add(base_q, wr_idx_i);
  assign base_d  = wrap_add(base_q, AW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (ctl_i.pop) begin
      base_q <= base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* sv/preemptive_sorted_ready_queue_core.sv */
// preemptive_sorted_ready_queue_core: sorted ready queue scheduler, uses psrq_pkg and psrq_ring
// arrival: compare from the head to the insert point, then one shift step per entry behind it,
// then the write of the new entry, the tick on the head entry and the head read before the strobe;
// tick-only or dropped arrival: only the tick on the head entry and the head read
// busy stays high until the strobe; next start is taken in the strobe cycle
// reset empties the queue and sets remaining-time mode; entries need no clearing pass
module preemptive_sorted_ready_queue_core import psrq_pkg::*; #(
  parameter int QUEUE_DEPTH = DefQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  sched_in_t  item_i,
  output logic       result_valid_o,
  output sched_out_t result_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  localparam int AW    = $clog2(QUEUE_DEPTH);
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int CntXW = (CntW > QCountW) ? CntW : QCountW;

  typedef enum logic [2:0] {
    S_IDLE, S_INS_SCAN, S_INS_SHIFT, S_INS_PUT, S_TICK_RD, S_TICK_EX, S_HEAD_RD, S_HEAD_EX
  } state_e;

  state_e            state_q, state_d;
  sched_in_t         item_q, item_d;
  logic [AW-1:0]     j_q, j_d;
  logic [AW-1:0]     p_q, p_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              fin_v_q, fin_v_d;
  logic [IdW-1:0]    fin_id_q, fin_id_d;
  logic              pre_q, pre_d;
  logic              drop_q, drop_d;
  logic              mode_q;
  logic              res_v_q, res_v_d;
  sched_out_t        res_q, res_d;

  ring_ctl_t         ctl;
  logic [AW-1:0]     rd_idx, wr_idx;
  slot_t             wr_data, rd_data, new_slot;
  logic [TimeW-1:0]  new_key;
  logic              go_behind;
  logic [CntXW-1:0]  cnt_ext;

  psrq_ring #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .AW         (AW)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .rd_idx_i (rd_idx),
    .wr_idx_i (wr_idx),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data)
  );

  assign new_slot.id        = item_q.process_id;
  assign new_slot.prio      = item_q.priority_req;
  assign new_slot.remaining = item_q.burst_time;
  assign new_key   = key_of(mode_q, new_slot);
  // first stored entry with key >= new key marks the insert point
  assign go_behind = key_of(mode_q, rd_data) >= new_key;
  assign cnt_ext   = CntXW'(cnt_q);

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    j_d      = j_q;
    p_d      = p_q;
    cnt_d    = cnt_q;
    fin_v_d  = fin_v_q;
    fin_id_d = fin_id_q;
    pre_d    = pre_q;
    drop_d   = drop_q;
    res_v_d  = 1'b0;
    res_d    = res_q;
    ctl      = '0;
    rd_idx   = '0;
    wr_idx   = '0;
    wr_data  = new_slot;

    res_d.finished_valid = fin_v_q;
    res_d.finished_id    = fin_id_q;
    res_d.preempted      = pre_q;
    res_d.dropped        = drop_q;
    res_d.queue_count    = cnt_ext[QCountW-1:0];
    res_d.running_valid  = 1'b0;
    res_d.running_id     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          item_d   = item_i;
          fin_v_d  = 1'b0;
          fin_id_d = '0;
          pre_d    = 1'b0;
          drop_d   = 1'b0;
          j_d      = cnt_q[AW-1:0];
          p_d      = '0;
          if (item_i.kind == KindTickOnly) begin
            state_d = S_TICK_RD;
          end else if (cnt_q >= CntW'(QUEUE_DEPTH)) begin
            drop_d  = 1'b1;
            state_d = S_TICK_RD;
          end else if (cnt_q == '0) begin
            state_d = S_INS_PUT;
          end else begin
            // first compare needs the head entry
            ctl.rd_en = 1'b1;
            rd_idx    = '0;
            state_d   = S_INS_SCAN;
          end
        end
      end
      S_INS_SCAN: begin
        if (go_behind) begin
          // insert point found, start moving entries from the tail
          ctl.rd_en = 1'b1;
          rd_idx    = j_q - AW'(1);
          state_d   = S_INS_SHIFT;
        end else begin
          p_d = p_q + AW'(1);
          if (p_q + AW'(1) == j_q) begin
            state_d = S_INS_PUT;
          end else begin
            ctl.rd_en = 1'b1;
            rd_idx    = p_q + AW'(1);
          end
        end
      end
      S_INS_SHIFT: begin
        ctl.wr_en = 1'b1;
        wr_idx    = j_q;
        wr_data   = rd_data;
        j_d       = j_q - AW'(1);
        if (j_q - AW'(1) > p_q) begin
          // fetch the next entry toward the head while this one moves
          ctl.rd_en = 1'b1;
          rd_idx    = j_q - AW'(1) - AW'(1);
        end else begin
          state_d = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        ctl.wr_en = 1'b1;
        wr_idx    = p_q;
        pre_d     = (p_q == '0) && (cnt_q != '0);
        cnt_d     = cnt_q + CntW'(1);
        state_d   = S_TICK_RD;
      end
      S_TICK_RD: begin
        if (cnt_q == '0) begin
          res_v_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          ctl.rd_en = 1'b1;
          rd_idx    = '0;
          state_d   = S_TICK_EX;
        end
      end
      S_TICK_EX: begin
        if (rd_data.remaining <= TimeW'(1)) begin
          fin_v_d  = 1'b1;
          fin_id_d = rd_data.id;
          ctl.pop  = 1'b1;
          cnt_d    = cnt_q - CntW'(1);
        end else begin
          ctl.wr_en         = 1'b1;
          wr_idx            = '0;
          wr_data           = rd_data;
          wr_data.remaining = rd_data.remaining - TimeW'(1);
        end
        state_d = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        if (cnt_q == '0) begin
          res_v_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          ctl.rd_en = 1'b1;
          rd_idx    = '0;
          state_d   = S_HEAD_EX;
        end
      end
      S_HEAD_EX: begin
        res_d.running_valid = 1'b1;
        res_d.running_id    = rd_data.id;
        res_v_d             = 1'b1;
        state_d             = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (!res_v_d) begin
      res_d = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      item_q   <= '0;
      j_q      <= '0;
      p_q      <= '0;
      cnt_q    <= '0;
      fin_v_q  <= 1'b0;
      fin_id_q <= '0;
      pre_q    <= 1'b0;
      drop_q   <= 1'b0;
      mode_q   <= ModeRemaining;
      res_v_q  <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      item_q   <= item_d;
      j_q      <= j_d;
      p_q      <= p_d;
      cnt_q    <= cnt_d;
      fin_v_q  <= fin_v_d;
      fin_id_q <= fin_id_d;
      pre_q    <= pre_d;
      drop_q   <= drop_d;
      res_v_q  <= res_v_d;
      res_q    <= res_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

  // results only appear once the sequencer is back in idle
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("start transfer did not raise busy");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QUEUE_DEPTH))
    else $error("held count beyond queue depth");

  a_drop_no_preempt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.dropped) |-> (!result_o.preempted && result_o.running_valid))
    else $error("dropped arrival reported as preempting or queue empty");

endmodule
